// ===== rtl/core/magma_block_cipher_assert.svh =====
`ifndef MAGMA_BLOCK_CIPHER_ASSERT_SVH
`define MAGMA_BLOCK_CIPHER_ASSERT_SVH

// Checked at every rising edge outside reset.
`define MAGMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define MAGMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/magma_pkg.sv =====
`timescale 1ns / 1ps

package magma_pkg;

  localparam int NUM_ROUNDS = 32;
  localparam int ROT_LEFT = 11;
  localparam int NUM_KEY_WORDS = 4;
  localparam int CFG_INDEX_W = 3;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_3 = 3'd3;

  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  typedef logic [31:0] half_t;

  typedef struct packed {
    logic  valid;
    logic  cmd;
    half_t left;
    half_t right;
  } stage_t;

  function automatic half_t subst(input half_t x);
    half_t r;
    r = '0;
    for (int n = 0; n < 8; n++) begin
      r[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic half_t round_fn(input half_t k, input half_t x);
    half_t t;
    t = subst(x + k);
    return (t << ROT_LEFT) | (t >> (32 - ROT_LEFT));
  endfunction

  // Round key number (K1 is 0) used by encryption round r.
  function automatic logic [2:0] key_index(input logic [4:0] r);
    logic [2:0] idx;
    if (r < 5'd24) begin
      idx = r[2:0];
    end else begin
      idx = 3'd7 - r[2:0];
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/magma_key_regs.sv =====
`timescale 1ns / 1ps

module magma_key_regs
  import magma_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  output half_t [7:0]            round_keys
);

  logic [63:0] key_word [NUM_KEY_WORDS];

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        KEY_WORD_0: key_word[0] <= cfg_data;
        KEY_WORD_1: key_word[1] <= cfg_data;
        KEY_WORD_2: key_word[2] <= cfg_data;
        KEY_WORD_3: key_word[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_KEY_WORDS; i++) begin
      round_keys[2*i]     = key_word[i][63:32];
      round_keys[2*i + 1] = key_word[i][31:0];
    end
  end

endmodule

// ===== rtl/core/magma_round.sv =====
`timescale 1ns / 1ps

module magma_round
  import magma_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  half_t  enc_key,
  input  half_t  dec_key,
  input  stage_t up,
  output logic   up_ready,
  output stage_t dn,
  input  logic   dn_ready
);

  half_t key;
  half_t mixed;

  assign up_ready = !dn.valid || dn_ready;
  assign key      = (up.cmd == CMD_DECRYPT) ? dec_key : enc_key;
  assign mixed    = round_fn(key, up.right) ^ up.left;

  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      dn.cmd   <= up.cmd;
      dn.left  <= up.right;
      dn.right <= mixed;
    end
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (up_ready) begin
      dn.valid <= up.valid;
    end
  end

endmodule

// ===== rtl/core/magma_block_cipher.sv =====
`timescale 1ns / 1ps

// Magma 64-bit block cipher, 32 rounds, one round per pipeline stage. A new word
// is taken every cycle outside reset unless the output stalls, and each word passes
// through the 32 round stages in order, each holding one modular add and one S-box
// layer. Stages hand words on with their own valid and ready, so empty stages fill
// while the output word waits. The 256-bit key lives in four 64-bit registers that
// reset to zero and must be written only while the pipeline is empty; writes with
// an index of four or more are ignored.

`include "magma_block_cipher_assert.svh"

module magma_block_cipher
  import magma_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [63:0]            block_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            block_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  half_t [7:0]             round_keys;
  stage_t                  stg  [NUM_ROUNDS+1];
  logic [NUM_ROUNDS:0]     rdy;
  logic [NUM_ROUNDS-1:0]   stage_valid;
  logic                    in_fire;
  logic                    out_fire;

  magma_key_regs u_keys (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (round_keys)
  );

  assign stg[0] = {in_valid, cmd, block_in};

  assign in_ready = rdy[0] && !rst;
  assign rdy[NUM_ROUNDS] = out_ready;

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    localparam logic [4:0] ENC_STEP = 5'(r);
    localparam logic [4:0] DEC_STEP = 5'(NUM_ROUNDS - 1 - r);

    magma_round u_round (
      .clk      (clk),
      .rst      (rst),
      .enc_key  (round_keys[key_index(ENC_STEP)]),
      .dec_key  (round_keys[key_index(DEC_STEP)]),
      .up       (stg[r]),
      .up_ready (rdy[r]),
      .dn       (stg[r+1]),
      .dn_ready (rdy[r+1])
    );

    assign stage_valid[r] = stg[r+1].valid;
  end

  // Every stage swaps the halves, so the last swap is undone here.
  assign out_valid = stg[NUM_ROUNDS].valid;
  assign block_out = {stg[NUM_ROUNDS].right, stg[NUM_ROUNDS].left};

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  `MAGMA_ASSERT(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with empty output")
  `MAGMA_ASSERT(a_word_count,
    !$past(rst) |-> ($countones(stage_valid) ==
      $past($countones(stage_valid)) + $past(in_fire) - $past(out_fire)),
    "word lost or duplicated in pipeline")
  `MAGMA_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

endmodule
